### src/pmpc_pkg.sv
// Shared types and constants for the skyline point counter.
package pmpc_pkg;

    // Width of the rank fields on the input ports.
    localparam int IN_RANK_W = 16;

    // Width and ceiling of the reported count.
    localparam int COUNT_W = 9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    // Control flags that travel with a word down the cell chain.
    typedef struct packed {
        logic vld;
        logic last;
        logic beaten;
        logic found;
    } pmpc_tok_t;

endpackage

### src/pmpc_cell.sv
// One staircase cell: holds a kept point and checks the passing word against it.
module pmpc_cell
    import pmpc_pkg::*;
#(
    parameter int RW  = 16,
    parameter int IW  = 8,
    parameter int CW  = 9,
    parameter int IDX = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  pmpc_tok_t     tok_in,
    input  logic [RW-1:0] a_in,
    input  logic [RW-1:0] b_in,
    input  logic [IW-1:0] idx_in,
    input  logic [CW-1:0] count_in,
    output pmpc_tok_t     tok_out,
    output logic [RW-1:0] a_out,
    output logic [RW-1:0] b_out,
    output logic [IW-1:0] idx_out,
    output logic [CW-1:0] count_out,
    input  logic          clr,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_idx,
    input  logic [RW-1:0] wr_a,
    input  logic [RW-1:0] wr_b
);

    logic          valid_reg;
    logic          valid_next;
    logic [RW-1:0] first_reg;
    logic [RW-1:0] second_reg;

    pmpc_tok_t     tok_reg;
    pmpc_tok_t     tok_next;
    logic [RW-1:0] a_reg;
    logic [RW-1:0] b_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] idx_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic          dom_by_cell;
    logic          kill;
    logic          keep;
    logic          wr_hit;

    // A kept point equal to the word beats it rather than being removed by it.
    // Kept points form an antichain, so a word that removes a cell can never be
    // beaten further down the chain, and the removal is safe at once.
    assign dom_by_cell = valid_reg && (first_reg <= a_in) && (second_reg <= b_in);
    assign kill        = valid_reg && (a_in <= first_reg) && (b_in <= second_reg)
                         && !dom_by_cell;
    assign keep        = valid_reg && !kill;
    assign wr_hit      = wr_en && (wr_idx == IW'(IDX));

    always_comb
    begin
        tok_next        = tok_in;
        tok_next.beaten = tok_in.beaten | dom_by_cell;
        tok_next.found  = tok_in.found | !keep;
        idx_next        = tok_in.found ? idx_in : IW'(IDX);
        count_next      = count_in + CW'(keep);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (clr)
        begin
            valid_next = 1'b0;
        end
        else if (wr_hit)
        begin
            valid_next = 1'b1;
        end
        else if (tok_in.vld)
        begin
            valid_next = keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            first_reg  <= wr_a;
            second_reg <= wr_b;
        end
        a_reg     <= a_in;
        b_reg     <= b_in;
        idx_reg   <= idx_next;
        count_reg <= count_next;
    end

    assign tok_out   = tok_reg;
    assign a_out     = a_reg;
    assign b_out     = b_reg;
    assign idx_out   = idx_reg;
    assign count_out = count_reg;

endmodule

### src/pareto_minimal_point_count.sv
// A word moves down the chain of MAX_POINTS cells, registered in each cell, and the
// staircase is updated as it leaves the last cell; the count of a set is registered
// first in a pending register and then in the output register.
// The block takes a new word only after the previous one has left the chain; after the
// last word of a set it also waits while that count is pending behind a held output.
// Reset clears every valid bit, the overflow-seen flag and all handshake state at once.
module pareto_minimal_point_count
    import pmpc_pkg::*;
#(
    parameter int MAX_POINTS = 256,
    parameter int RANK_BITS  = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [IN_RANK_W-1:0] first_rank,
    input  logic [IN_RANK_W-1:0] second_rank,
    input  logic                 is_last,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [COUNT_W-1:0]   pass_count,
    output logic                 overflow
);

    localparam int RW = (RANK_BITS < IN_RANK_W) ? RANK_BITS : IN_RANK_W;
    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int WW = CW + COUNT_W + 1;

    pmpc_tok_t     tok_c [0:MAX_POINTS];
    logic [RW-1:0] a_c   [0:MAX_POINTS];
    logic [RW-1:0] b_c   [0:MAX_POINTS];
    logic [IW-1:0] idx_c [0:MAX_POINTS];
    logic [CW-1:0] cnt_c [0:MAX_POINTS];

    logic               accept;
    logic               busy_reg;
    logic               busy_next;
    logic               ovf_seen_reg;
    logic               ovf_seen_next;
    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic [COUNT_W-1:0] pend_count_reg;
    logic               pend_ovf_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_ovf_reg;
    logic               out_load;

    pmpc_tok_t          tail;
    logic               ins;
    logic [CW-1:0]      count_f;
    logic [WW-1:0]      count_wide;
    logic [COUNT_W-1:0] count_sat;
    logic               ovf_f;
    logic               clr;
    logic               wr_en;

    assign accept = in_valid && !in_stall;
    assign in_stall = busy_reg || pend_valid_reg;

    // Head of the chain: the accepted word with fresh flags.
    always_comb
    begin
        tok_c[0].vld    = accept;
        tok_c[0].last   = is_last;
        tok_c[0].beaten = 1'b0;
        tok_c[0].found  = 1'b0;
        a_c[0]          = first_rank[RW-1:0];
        b_c[0]          = second_rank[RW-1:0];
        idx_c[0]        = '0;
        cnt_c[0]        = '0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_POINTS; gi++)
        begin : g_cell
            pmpc_cell #(
                .RW  (RW),
                .IW  (IW),
                .CW  (CW),
                .IDX (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .tok_in    (tok_c[gi]),
                .a_in      (a_c[gi]),
                .b_in      (b_c[gi]),
                .idx_in    (idx_c[gi]),
                .count_in  (cnt_c[gi]),
                .tok_out   (tok_c[gi+1]),
                .a_out     (a_c[gi+1]),
                .b_out     (b_c[gi+1]),
                .idx_out   (idx_c[gi+1]),
                .count_out (cnt_c[gi+1]),
                .clr       (clr),
                .wr_en     (wr_en),
                .wr_idx    (idx_c[MAX_POINTS]),
                .wr_a      (a_c[MAX_POINTS]),
                .wr_b      (b_c[MAX_POINTS])
            );
        end
    endgenerate

    assign tail = tok_c[MAX_POINTS];

    // End of the walk: place an unbeaten word in the lowest free cell, or note the overflow.
    always_comb
    begin
        ins        = tail.vld && !tail.beaten && tail.found;
        count_f    = cnt_c[MAX_POINTS] + CW'(ins);
        ovf_f      = ovf_seen_reg || (tail.vld && !tail.beaten && !tail.found);
        count_wide = WW'(count_f);
        count_sat  = (count_wide > WW'(COUNT_MAX)) ? COUNT_MAX : count_wide[COUNT_W-1:0];
        clr        = tail.vld && tail.last;
        wr_en      = ins && !tail.last;
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tail.vld)
        begin
            busy_next = 1'b0;
        end

        ovf_seen_next = ovf_seen_reg;
        if (clr)
        begin
            ovf_seen_next = 1'b0;
        end
        else if (tail.vld)
        begin
            ovf_seen_next = ovf_f;
        end

        out_load        = pend_valid_reg && (!out_valid_reg || !out_stall);
        pend_valid_next = clr || (pend_valid_reg && !out_load);
        out_valid_next  = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            ovf_seen_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            ovf_seen_reg   <= ovf_seen_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr)
        begin
            pend_count_reg <= count_sat;
            pend_ovf_reg   <= ovf_f;
        end
        if (out_load)
        begin
            out_count_reg <= pend_count_reg;
            out_ovf_reg   <= pend_ovf_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pass_count = out_count_reg;
    assign overflow   = out_ovf_reg;

    a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tail.vld |-> busy_reg)
        else $error("word left the chain while the block was not busy");

    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !busy_reg)
        else $error("pending result while a word is still in the chain");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("accepted word did not mark the block busy");

    a_found_room: assert property (@(posedge clk) disable iff (!rst_n)
        (tail.vld && tail.found) |-> (cnt_c[MAX_POINTS] < CW'(MAX_POINTS)))
        else $error("free cell reported with a full staircase");

    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        clr |=> pend_valid_reg)
        else $error("last word did not produce a result");

endmodule
